// ===== rtl/lbvs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the vertex skinning block.
// Depends on nothing; every other file refers to it by scoped names.
package lbvs_pkg;

    localparam int WORDS_PER_BONE = 12;
    localparam logic [3:0] ELEM_LIMIT = 4'd12;
    localparam int ADDR_FULL_W = 12;
    localparam int QUEUE_DEPTH = 2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_WEIGHT = 1'b1;

    typedef struct packed {
        logic               action;
        logic [5:0]         joint_index;
        logic [3:0]         matrix_element;
        logic signed [31:0] matrix_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
        logic [15:0]        weight_bias;
        logic               last_weight;
    } t_in;

    typedef struct packed {
        logic signed [31:0] skinned_x;
        logic signed [31:0] skinned_y;
        logic signed [31:0] skinned_z;
        logic signed [31:0] skinned_nx;
        logic signed [31:0] skinned_ny;
        logic signed [31:0] skinned_nz;
    } t_out;

    typedef struct packed {
        logic jnt_ok;
        t_in  item;
    } t_cmd;

    function automatic logic signed [47:0] sat48(input logic signed [66:0] v);
        logic signed [47:0] res;
        if (v[66:47] == '0 || v[66:47] == '1) begin
            res = v[47:0];
        end else if (v[66]) begin
            res = {1'b1, 47'b0};
        end else begin
            res = {1'b0, {47{1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] res;
        if (v[47:31] == '0 || v[47:31] == '1) begin
            res = v[31:0];
        end else if (v[47]) begin
            res = {1'b1, 31'b0};
        end else begin
            res = {1'b0, {31{1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== rtl/lbvs_front.sv =====
`timescale 1ns / 1ps
// Input stage: registers each incoming word, checks joint and element range,
// and drops palette writes that fall outside the store. Uses lbvs_pkg.
module lbvs_front #(
    parameter int MAX_BONES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lbvs_pkg::t_in   i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output lbvs_pkg::t_cmd  o_cmd
);

    localparam logic [8:0] BONE_LIMIT = 9'(MAX_BONES);

    logic           r_vld;
    logic           n_vld;
    lbvs_pkg::t_cmd r_cmd;
    logic           w_jnt_ok;
    logic           w_keep;
    logic           w_accept;

    assign w_jnt_ok = {3'b0, i_item.joint_index} < BONE_LIMIT;
    assign w_keep = (i_item.action == lbvs_pkg::ACT_WEIGHT) ||
                    (w_jnt_ok && (i_item.matrix_element < lbvs_pkg::ELEM_LIMIT));
    assign o_ready = !r_vld || i_ready;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_vld = r_vld;
        if (w_accept) begin
            n_vld = w_keep;
        end else if (r_vld && i_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.jnt_ok <= w_jnt_ok;
            r_cmd.item <= i_item;
        end
    end

    assign o_valid = r_vld;
    assign o_cmd = r_cmd;

endmodule

// ===== rtl/lbvs_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the input stage and the skinning engine.
// Uses lbvs_pkg for the command type and depth.
module lbvs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  lbvs_pkg::t_cmd  i_cmd,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output lbvs_pkg::t_cmd  o_cmd
);

    localparam int DEPTH = lbvs_pkg::QUEUE_DEPTH;
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    lbvs_pkg::t_cmd r_buf [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           w_push;
    logic           w_pop;

    assign o_push_ready = r_count != CNT_FULL;
    assign o_pop_valid = r_count != '0;
    assign w_push = i_push_valid && o_push_ready;
    assign w_pop = i_pop && o_pop_valid;
    assign o_cmd = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/lbvs_back.sv =====
`timescale 1ns / 1ps
// Skinning engine: bone palette memory, a sequencer over matrix words with two
// shared multipliers, the blend accumulators and the result register. Uses lbvs_pkg.
module lbvs_back #(
    parameter int MAX_BONES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  lbvs_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output lbvs_pkg::t_out  o_data
);

    localparam int DEPTH = MAX_BONES * lbvs_pkg::WORDS_PER_BONE;
    localparam int AW = $clog2(DEPTH);
    localparam int FW = lbvs_pkg::ADDR_FULL_W;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_RD   = 9'b000000010,
        ST_MUL  = 9'b000000100,
        ST_ADD  = 9'b000001000,
        ST_TRN  = 9'b000010000,
        ST_WLO  = 9'b000100000,
        ST_WHI  = 9'b001000000,
        ST_ACC  = 9'b010000000,
        ST_EMIT = 9'b100000000
    } t_state;

    logic [31:0]        r_mem [DEPTH];
    t_state             r_state;
    t_state             n_state;
    lbvs_pkg::t_cmd     r_cmd;
    logic [AW-1:0]      r_raddr;
    logic [1:0]         r_col;
    logic [1:0]         r_row;
    logic [31:0]        r_rdata;
    logic signed [65:0] r_pp;
    logic signed [65:0] r_pn;
    logic signed [65:0] r_qp;
    logic signed [65:0] r_qn;
    logic signed [65:0] r_sp;
    logic signed [65:0] r_sn;
    logic signed [47:0] r_tp;
    logic signed [47:0] r_tn;
    logic signed [47:0] r_accp [3];
    logic signed [47:0] r_accn [3];
    logic               r_ovld;
    lbvs_pkg::t_out     r_out;

    logic               w_start;
    logic               w_is_wt;
    logic               w_emit;
    logic [FW-1:0]      w_addr_full;
    logic [31:0]        w_mword;
    logic [31:0]        w_pos_sel;
    logic [31:0]        w_nrm_sel;
    logic signed [32:0] w_ap;
    logic signed [32:0] w_bp;
    logic signed [32:0] w_an;
    logic signed [32:0] w_bn;
    logic signed [65:0] w_mp;
    logic signed [65:0] w_mn;
    logic signed [65:0] w_shp;
    logic signed [65:0] w_shn;
    logic signed [47:0] w_tp;
    logic signed [47:0] w_tn;
    logic signed [65:0] w_totp;
    logic signed [65:0] w_totn;
    logic signed [65:0] w_cp;
    logic signed [65:0] w_cn;
    logic signed [47:0] w_accp;
    logic signed [47:0] w_accn;
    logic signed [47:0] w_newp;
    logic signed [47:0] w_newn;

    assign w_is_wt = i_cmd.item.action == lbvs_pkg::ACT_WEIGHT;
    assign w_start = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_cmd_pop = w_start;
    assign w_emit = (r_state == ST_EMIT) && (!r_ovld || i_ready);

    assign w_addr_full = ({6'b0, i_cmd.item.joint_index} << 3) +
                         ({6'b0, i_cmd.item.joint_index} << 2) +
                         (w_is_wt ? {FW{1'b0}} : {8'b0, i_cmd.item.matrix_element});

    assign w_mword = r_cmd.jnt_ok ? r_rdata : 32'b0;

    always_comb begin
        case (r_col)
            2'd0: begin
                w_pos_sel = r_cmd.item.pos_x;
                w_nrm_sel = r_cmd.item.norm_x;
            end
            2'd1: begin
                w_pos_sel = r_cmd.item.pos_y;
                w_nrm_sel = r_cmd.item.norm_y;
            end
            2'd2: begin
                w_pos_sel = r_cmd.item.pos_z;
                w_nrm_sel = r_cmd.item.norm_z;
            end
            default: begin
                w_pos_sel = 32'b0;
                w_nrm_sel = 32'b0;
            end
        endcase
    end

    always_comb begin
        w_ap = '0;
        w_bp = '0;
        w_an = '0;
        w_bn = '0;
        case (r_state)
            ST_MUL: begin
                w_ap = $signed({w_mword[31], w_mword});
                w_bp = $signed({w_pos_sel[31], w_pos_sel});
                w_an = $signed({w_mword[31], w_mword});
                w_bn = $signed({w_nrm_sel[31], w_nrm_sel});
            end
            ST_WLO: begin
                w_ap = $signed({9'b0, r_tp[23:0]});
                w_bp = $signed({17'b0, r_cmd.item.weight_bias});
                w_an = $signed({9'b0, r_tn[23:0]});
                w_bn = $signed({17'b0, r_cmd.item.weight_bias});
            end
            ST_WHI: begin
                w_ap = $signed({{9{r_tp[47]}}, r_tp[47:24]});
                w_bp = $signed({17'b0, r_cmd.item.weight_bias});
                w_an = $signed({{9{r_tn[47]}}, r_tn[47:24]});
                w_bn = $signed({17'b0, r_cmd.item.weight_bias});
            end
            default: begin
                w_ap = '0;
                w_bp = '0;
                w_an = '0;
                w_bn = '0;
            end
        endcase
    end

    assign w_mp = w_ap * w_bp;
    assign w_mn = w_an * w_bn;

    assign w_shp = r_sp >>> FRAC_BITS;
    assign w_shn = r_sn >>> FRAC_BITS;
    assign w_tp = lbvs_pkg::sat48($signed({w_shp[65], w_shp}) +
                                  $signed({{35{w_mword[31]}}, w_mword}));
    assign w_tn = lbvs_pkg::sat48($signed({w_shn[65], w_shn}));

    assign w_totp = (r_qp <<< 24) + r_pp;
    assign w_totn = (r_qn <<< 24) + r_pn;
    assign w_cp = w_totp >>> 15;
    assign w_cn = w_totn >>> 15;
    assign w_accp = r_accp[r_row];
    assign w_accn = r_accn[r_row];
    assign w_newp = lbvs_pkg::sat48($signed({{19{w_accp[47]}}, w_accp}) +
                                    $signed({w_cp[65], w_cp}));
    assign w_newn = lbvs_pkg::sat48($signed({{19{w_accn[47]}}, w_accn}) +
                                    $signed({w_cn[65], w_cn}));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start && w_is_wt) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = (r_col == 2'd3) ? ST_TRN : ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_state = ST_RD;
            end
            ST_TRN: begin
                n_state = ST_WLO;
            end
            ST_WLO: begin
                n_state = ST_WHI;
            end
            ST_WHI: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_row != 2'd2) begin
                    n_state = ST_RD;
                end else if (r_cmd.item.last_weight) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col <= '0;
            r_row <= '0;
            r_ovld <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_accp[i] <= '0;
                r_accn[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_start && w_is_wt) begin
                r_col <= '0;
                r_row <= '0;
            end
            if (r_state == ST_ADD) begin
                r_col <= r_col + 2'd1;
            end
            if (r_state == ST_ACC) begin
                r_col <= '0;
                r_row <= r_row + 2'd1;
                r_accp[r_row] <= w_newp;
                r_accn[r_row] <= w_newn;
            end
            if (w_emit) begin
                r_ovld <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r_accp[i] <= '0;
                    r_accn[i] <= '0;
                end
            end else if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start && !w_is_wt) begin
            r_mem[w_addr_full[AW-1:0]] <= i_cmd.item.matrix_value;
        end
        if (r_state == ST_RD) begin
            r_rdata <= r_mem[r_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start && w_is_wt) begin
            r_cmd <= i_cmd;
            r_raddr <= w_addr_full[AW-1:0];
            r_sp <= '0;
            r_sn <= '0;
        end
        case (r_state)
            ST_RD: begin
                r_raddr <= r_raddr + AW'(1);
            end
            ST_MUL: begin
                r_pp <= w_mp;
                r_pn <= w_mn;
            end
            ST_ADD: begin
                r_sp <= r_sp + r_pp;
                r_sn <= r_sn + r_pn;
            end
            ST_TRN: begin
                r_tp <= w_tp;
                r_tn <= w_tn;
            end
            ST_WLO: begin
                r_pp <= w_mp;
                r_pn <= w_mn;
            end
            ST_WHI: begin
                r_qp <= w_mp;
                r_qn <= w_mn;
            end
            ST_ACC: begin
                r_sp <= '0;
                r_sn <= '0;
            end
            default: begin
            end
        endcase
        if (w_emit) begin
            r_out.skinned_x <= lbvs_pkg::sat32(r_accp[0]);
            r_out.skinned_y <= lbvs_pkg::sat32(r_accp[1]);
            r_out.skinned_z <= lbvs_pkg::sat32(r_accp[2]);
            r_out.skinned_nx <= lbvs_pkg::sat32(r_accn[0]);
            r_out.skinned_ny <= lbvs_pkg::sat32(r_accn[1]);
            r_out.skinned_nz <= lbvs_pkg::sat32(r_accn[2]);
        end
    end

    assign o_valid = r_ovld;
    assign o_data = r_out;

endmodule

// ===== rtl/linear_blend_vertex_skinning.sv =====
`timescale 1ns / 1ps
// Top level of the linear blend vertex skinning block.
// Instantiates lbvs_front, lbvs_queue and lbvs_back; uses lbvs_pkg.
//
// A palette write word is stored while the engine stays idle. A weight word
// walks the bone's twelve matrix words through the single palette read port
// and a shared pair of 33x33 multipliers that also apply the bias, and when
// it is marked last it hands its sums to the result register. Input words are
// held in a two-entry queue, so the input side keeps accepting while the engine
// works until the queue and the input register are full. A finished result
// waits in its own register and holds back the next vertex only if still unread
// when that vertex is done. Reading a palette word never written gives undefined results.
module linear_blend_vertex_skinning #(
    parameter int MAX_BONES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lbvs_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lbvs_pkg::t_out o_out_data
);

    logic           w_f_valid;
    logic           w_q_ready;
    lbvs_pkg::t_cmd w_f_cmd;
    logic           w_q_valid;
    logic           w_pop;
    lbvs_pkg::t_cmd w_q_cmd;

    lbvs_front #(
        .MAX_BONES(MAX_BONES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .o_valid (w_f_valid),
        .i_ready (w_q_ready),
        .o_cmd   (w_f_cmd)
    );

    lbvs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_q_ready),
        .i_cmd        (w_f_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop        (w_pop),
        .o_cmd        (w_q_cmd)
    );

    lbvs_back #(
        .MAX_BONES(MAX_BONES),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("engine popped an empty queue");

    a_stall_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_f_valid && !w_q_ready))
        else $error("input stalled without a held word and a full queue");

endmodule
